@@ sv/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared constants and controller/datapath interface types for the clock
// (second-chance) page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 16;
  localparam int unsigned PAGE_BITS_DEF  = 8;

  localparam int unsigned FRAMES_W = 5;
  localparam int unsigned PAGE_W   = 8;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned TOTAL_W  = 16;

  localparam logic [FRAMES_W-1:0] FRAMES_RST = 5'd16;
  localparam logic [TOTAL_W-1:0]  COUNT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic capture;
    logic search;
    logic sweep;
    logic push;
  } cpr_cmd_t;

  typedef struct packed {
    logic miss_full;
    logic ref_set;
    logic out_free;
  } cpr_sts_t;

endpackage

@@ sv/cpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer: capture a beat, search the slots, sweep the hand one slot per
// cycle on a full miss, then hand the result to the output register.
// ----------------------------------------------------------------------------
module cpr_ctrl
  import cpr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  cpr_sts_t sts_i,
  output cpr_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SWEEP  = 2'd2;
  localparam logic [1:0] S_PUSH   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = sts_i.miss_full ? S_SWEEP : S_PUSH;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (!sts_i.ref_set) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_SEARCH))
    else $error("accepted beat did not enter search");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && !sts_i.ref_set) |=> (state_q == S_PUSH))
    else $error("sweep did not stop at a clear reference bit");

  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> !in_stall_o)
    else $error("input not reopened after result push");

endmodule

@@ sv/cpr_dpath.sv @@
// ----------------------------------------------------------------------------
// cpr_dpath
// Slot store with parallel page match, reference bits, clock hand, fault
// counter, frame count register and output register.
// ----------------------------------------------------------------------------
module cpr_dpath
  import cpr_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [FRAMES_W-1:0] cfg_wdata_i,
  input  logic [PAGE_W-1:0]   page_number_i,
  input  logic                final_reference_i,
  input  cpr_cmd_t            cmd_i,
  output cpr_sts_t            sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                page_fault_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic                evicted_valid_o,
  output logic [PAGE_W-1:0]   evicted_page_o,
  output logic [TOTAL_W-1:0]  fault_total_o,
  output logic                total_is_final_o
);

  localparam int unsigned IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);

  logic [FRAMES_W-1:0]   frames_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic                  final_q;
  logic [PAGE_BITS-1:0]  slot_page_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  logic [MAX_FRAMES-1:0] ref_q;
  logic [IW-1:0]         hand_q;
  logic [IW-1:0]         sp_q;
  logic [TOTAL_W-1:0]    fault_cnt_q;

  logic                  res_fault_q;
  logic [IW-1:0]         res_slot_q;
  logic                  res_ev_valid_q;
  logic [PAGE_W-1:0]     res_ev_page_q;

  logic                  out_valid_q;
  logic                  out_fault_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic                  out_ev_valid_q;
  logic [PAGE_W-1:0]     out_ev_page_q;
  logic [TOTAL_W-1:0]    out_total_q;
  logic                  out_final_q;

  logic [CW-1:0] n_w;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic          emp;
  logic [IW-1:0] emp_idx;
  logic [IW-1:0] start_idx;
  logic [IW-1:0] sp_next;
  logic          pg_we;
  logic [IW-1:0] pg_waddr;

  always_comb begin
    if (frames_q == '0) begin
      n_w = CW'(1);
    end else if (32'(frames_q) > 32'(MAX_FRAMES)) begin
      n_w = CW'(MAX_FRAMES);
    end else begin
      n_w = CW'(frames_q);
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    emp     = 1'b0;
    emp_idx = '0;
    for (int i = 0; i < int'(MAX_FRAMES); i++) begin
      if (i < int'(n_w) && valid_q[i] && slot_page_q[i] == page_q) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
    for (int i = int'(MAX_FRAMES) - 1; i >= 0; i--) begin
      if (i < int'(n_w) && !valid_q[i]) begin
        emp     = 1'b1;
        emp_idx = IW'(i);
      end
    end
  end

  assign start_idx = (int'(hand_q) < int'(n_w)) ? hand_q : '0;
  assign sp_next   = (int'(sp_q) + 1 >= int'(n_w)) ? '0 : sp_q + 1'b1;

  assign sts_o.miss_full = !hit && !emp;
  assign sts_o.ref_set   = ref_q[sp_q];
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    pg_we    = 1'b0;
    pg_waddr = emp_idx;
    if (cmd_i.search && !hit && emp) begin
      pg_we = 1'b1;
    end else if (cmd_i.sweep && !ref_q[sp_q]) begin
      pg_we    = 1'b1;
      pg_waddr = sp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pg_we) begin
      slot_page_q[pg_waddr] <= page_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q  <= PAGE_BITS'(page_number_i);
      final_q <= final_reference_i;
    end
    if (cmd_i.search) begin
      res_fault_q    <= !hit;
      res_slot_q     <= hit ? hit_idx : emp_idx;
      res_ev_valid_q <= 1'b0;
      res_ev_page_q  <= '0;
    end else if (cmd_i.sweep && !ref_q[sp_q]) begin
      res_slot_q     <= sp_q;
      res_ev_valid_q <= 1'b1;
      res_ev_page_q  <= PAGE_W'(slot_page_q[sp_q]);
    end
    if (cmd_i.push) begin
      out_fault_q    <= res_fault_q;
      out_slot_q     <= SLOT_W'(res_slot_q);
      out_ev_valid_q <= res_ev_valid_q;
      out_ev_page_q  <= res_ev_page_q;
      out_total_q    <= fault_cnt_q;
      out_final_q    <= final_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= FRAMES_RST;
      valid_q     <= '0;
      ref_q       <= '0;
      hand_q      <= '0;
      sp_q        <= '0;
      fault_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frames_q <= cfg_wdata_i;
      end
      if (cmd_i.search) begin
        if (hit) begin
          ref_q[hit_idx] <= 1'b1;
        end else begin
          if (fault_cnt_q != COUNT_MAX) begin
            fault_cnt_q <= fault_cnt_q + 1'b1;
          end
          if (emp) begin
            valid_q[emp_idx] <= 1'b1;
          end else begin
            sp_q <= start_idx;
          end
        end
      end
      if (cmd_i.sweep) begin
        if (ref_q[sp_q]) begin
          ref_q[sp_q] <= 1'b0;
          sp_q        <= sp_next;
        end else begin
          valid_q[sp_q] <= 1'b1;
          hand_q        <= sp_next;
        end
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign page_fault_o     = out_fault_q;
  assign slot_index_o     = out_slot_q;
  assign evicted_valid_o  = out_ev_valid_q;
  assign evicted_page_o   = out_ev_page_q;
  assign fault_total_o    = out_total_q;
  assign total_is_final_o = out_final_q;

  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> fault_cnt_q >= $past(fault_cnt_q))
    else $error("fault counter went backwards");

  a_sweep_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sweep && sts_o.ref_set) |=>
      ($countones(ref_q) + 1 == $countones($past(ref_q))))
    else $error("sweep step did not clear exactly one reference bit");

  a_push_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> out_valid_q)
    else $error("pushed result not presented");

endmodule

@@ sv/clock_page_replacement.sv @@
// Flow: a hit or a fill into an empty slot passes the search and push states
// before its result shows; a replacement adds a sweep step per slot the hand visits.
// A new beat is taken only after the last result is pushed; the hand sweep
// tests one slot per cycle.
// Reset: slots empty, reference bits clear, hand and fault total zero,
// frames_in_use 16; no clearing pass, a beat can be taken right away.
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock (second-chance) page replacement over a small set of page frames.
// ----------------------------------------------------------------------------
module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [FRAMES_W-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PAGE_W-1:0]   page_number_i,
  input  logic                final_reference_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                page_fault_o,
  output logic [SLOT_W-1:0]   slot_index_o,
  output logic                evicted_valid_o,
  output logic [PAGE_W-1:0]   evicted_page_o,
  output logic [TOTAL_W-1:0]  fault_total_o,
  output logic                total_is_final_o
);

  cpr_cmd_t cmd;
  cpr_sts_t sts;

  cpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpr_dpath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .page_number_i     (page_number_i),
    .final_reference_i (final_reference_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .page_fault_o      (page_fault_o),
    .slot_index_o      (slot_index_o),
    .evicted_valid_o   (evicted_valid_o),
    .evicted_page_o    (evicted_page_o),
    .fault_total_o     (fault_total_o),
    .total_is_final_o  (total_is_final_o)
  );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the clock page replacement block: a behavioural
// copy of the slot table predicts every result beat, and directed and random
// tests run under random idling on both handshakes, but for one steady random pass.
// ----------------------------------------------------------------------------
module tb;
  import cpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned MAX_SHOWN   = 50;

  typedef struct packed {
    logic               fault;
    logic [SLOT_W-1:0]  slot;
    logic               ev_valid;
    logic [PAGE_W-1:0]  ev_page;
    logic [TOTAL_W-1:0] total;
    logic               fin;
  } ref_outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [FRAMES_W-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PAGE_W-1:0]   page_number_i;
  logic                final_reference_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                page_fault_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic                evicted_valid_o;
  logic [PAGE_W-1:0]   evicted_page_o;
  logic [TOTAL_W-1:0]  fault_total_o;
  logic                total_is_final_o;

  // behavioural slot table
  logic [FRAMES_W-1:0] frame_sel;
  logic [PAGE_W-1:0]   page_at [MAX_FRAMES_DEF];
  logic                resident [MAX_FRAMES_DEF];
  logic                touched [MAX_FRAMES_DEF];
  logic [SLOT_W-1:0]   hand_pos;
  logic [TOTAL_W-1:0]  faults;

  ref_outcome_t outcomes[$];
  int unsigned  errors;
  int unsigned  cycle_count;
  bit           steady;

  clock_page_replacement uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .page_number_i     (page_number_i),
    .final_reference_i (final_reference_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .page_fault_o      (page_fault_o),
    .slot_index_o      (slot_index_o),
    .evicted_valid_o   (evicted_valid_o),
    .evicted_page_o    (evicted_page_o),
    .fault_total_o     (fault_total_o),
    .total_is_final_o  (total_is_final_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned live_frames();
    if (frame_sel == 0) return 1;
    if (frame_sel > MAX_FRAMES_DEF) return MAX_FRAMES_DEF;
    return 32'(frame_sel);
  endfunction

  function automatic ref_outcome_t clock_lookup(logic [PAGE_W-1:0] pg, logic fin);
    int unsigned  n;
    int unsigned  h;
    int unsigned  i;
    logic         hit;
    logic         filled;
    ref_outcome_t r;
    n      = live_frames();
    hit    = 1'b0;
    filled = 1'b0;
    r      = '0;
    r.fin  = fin;
    for (i = 0; i < n; i++) begin
      if (resident[i] && page_at[i] == pg) begin
        hit    = 1'b1;
        r.slot = i[SLOT_W-1:0];
      end
    end
    if (hit) begin
      touched[r.slot] = 1'b1;
    end else begin
      r.fault = 1'b1;
      if (faults != COUNT_MAX) faults++;
      for (i = 0; i < n && !filled; i++) begin
        if (!resident[i]) begin
          r.slot = i[SLOT_W-1:0];
          filled = 1'b1;
        end
      end
      if (!filled) begin
        h = (32'(hand_pos) < n) ? 32'(hand_pos) : 0;
        while (touched[h]) begin
          touched[h] = 1'b0;
          h = (h + 1) % n;
        end
        r.slot     = h[SLOT_W-1:0];
        hand_pos   = SLOT_W'((h + 1) % n);
        r.ev_valid = 1'b1;
        r.ev_page  = page_at[h];
      end
      page_at[r.slot]  = pg;
      resident[r.slot] = 1'b1;
    end
    r.total = faults;
    return r;
  endfunction

  task automatic flag(input string field, input logic [15:0] want, input logic [15:0] got);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // one reference beat; valid stays high into the next call unless it idles
  task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic fin);
    if (!steady) begin
      while ($urandom_range(99) < 25) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i        <= 1'b1;
    page_number_i     <= pg;
    final_reference_i <= fin;
    do @(posedge clk_i); while (in_stall_o);
    outcomes.push_back(clock_lookup(pg, fin));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_frames(input logic [FRAMES_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    frame_sel = v;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_fill_hit();
    send_ref(8'h00, 1'b0);
    send_ref(8'hFF, 1'b0);
    send_ref(8'h00, 1'b0);
    send_ref(8'hFF, 1'b1);
  endtask

  task automatic test_sweep();
    set_frames(5'd3);
    send_ref(8'h5A, 1'b0);
    send_ref(8'hA5, 1'b0);
    send_ref(8'h00, 1'b0);
    send_ref(8'hFF, 1'b0);
    send_ref(8'h11, 1'b1);
  endtask

  // hand left past the shrunken frame count
  task automatic test_hand_beyond();
    set_frames(5'd4);
    send_ref(8'h22, 1'b0);
    send_ref(8'h33, 1'b0);
    send_ref(8'h44, 1'b0);
    set_frames(5'd2);
    send_ref(8'h66, 1'b0);
    send_ref(8'h77, 1'b1);
  endtask

  // same page in two slots; the highest one must hit
  task automatic test_duplicates();
    set_frames(5'd16);
    send_ref(8'h99, 1'b0);
    set_frames(5'd2);
    send_ref(8'h99, 1'b0);
    set_frames(5'd16);
    send_ref(8'h99, 1'b0);
    send_ref(8'h22, 1'b1);
  endtask

  task automatic test_frame_range();
    set_frames(5'd0);
    send_ref(8'h01, 1'b0);
    send_ref(8'h80, 1'b0);
    set_frames(5'd31);
    send_ref(8'h7F, 1'b0);
    send_ref(8'h99, 1'b0);
    set_frames(5'd17);
    send_ref(8'hFE, 1'b1);
  endtask

  task automatic test_random();
    logic [FRAMES_W-1:0] sel [9];
    logic [PAGE_W-1:0]   base;
    logic [PAGE_W-1:0]   pg;
    int unsigned         span;
    sel = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'd8, 5'd17, 5'd12};
    for (int p = 0; p < 9; p++) begin
      set_frames(sel[p]);
      steady = (p == 6);
      base   = PAGE_W'($urandom_range(0, 255));
      span   = live_frames() + $urandom_range(0, 4);
      for (int k = 0; k < 205; k++) begin
        if ($urandom_range(99) < 15) pg = PAGE_W'($urandom_range(0, 255));
        else pg = PAGE_W'(32'(base) + $urandom_range(0, span));
        send_ref(pg, $urandom_range(99) < 10);
        if ($urandom_range(199) == 0) drain();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_valid_i        <= 1'b0;
    page_number_i     <= '0;
    final_reference_i <= 1'b0;
    errors    = 0;
    steady    = 1'b0;
    frame_sel = FRAMES_RST;
    hand_pos  = '0;
    faults    = '0;
    for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
      page_at[i]  = '0;
      resident[i] = 1'b0;
      touched[i]  = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_hit();
    test_sweep();
    test_hand_beyond();
    test_duplicates();
    test_frame_range();
    test_random();

    drain();
    repeat (24) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial out_stall_i <= 1'b0;
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 25);
  end

  always @(posedge clk_i) begin : check_beats
    ref_outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcomes.size() == 0) begin
        flag("unexpected beat", 16'h0, {12'h0, slot_index_o});
      end else begin
        want = outcomes.pop_front();
        if (want.fault !== page_fault_o)
          flag("page_fault", 16'(want.fault), 16'(page_fault_o));
        if (want.slot !== slot_index_o)
          flag("slot_index", 16'(want.slot), 16'(slot_index_o));
        if (want.ev_valid !== evicted_valid_o)
          flag("evicted_valid", 16'(want.ev_valid), 16'(evicted_valid_o));
        if (want.ev_page !== evicted_page_o)
          flag("evicted_page", 16'(want.ev_page), 16'(evicted_page_o));
        if (want.total !== fault_total_o) flag("fault_total", want.total, fault_total_o);
        if (want.fin !== total_is_final_o)
          flag("total_is_final", 16'(want.fin), 16'(total_is_final_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d beats outstanding", $time, outcomes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
